// File: hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Byte substitution cipher package
// Shared widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TableSize = 256;
  localparam int unsigned MarkCntW  = 9;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [2:0]       cmd_t;
  typedef logic [1:0]       status_t;

  typedef enum logic [2:0] {
    CMD_LOAD_SEED = 3'd0,
    CMD_GEN_KEY   = 3'd1,
    CMD_STAGE     = 3'd2,
    CMD_COMMIT    = 3'd3,
    CMD_ENCRYPT   = 3'd4,
    CMD_DECRYPT   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SEED_EMPTY = 2'd1,
    ST_SEED_FULL  = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    seed_wr;
    logic    stage_wr;
    logic    marks_clr;
    logic    lookup_rd;
    logic    gen_init;
    logic    sw_seed_rd;
    logic    sw_rd_i;
    logic    sw_rd_j;
    logic    sw_wr_i;
    logic    sw_wr_j;
    logic    cp_rd;
    logic    cp_wr;
    logic    rb_rd;
    logic    rb_wr;
    logic    k_clr;
    logic    k_inc;
    logic    sp_clr;
    logic    sp_inc;
    logic    seed_clr;
    logic    st_ld;
    status_e st;
    logic    out_load;
  } bsc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic accepted;
    cmd_t command;
    logic seed_empty;
    logic seed_full;
    logic key_complete;
    logic k_last;
    logic out_free;
  } bsc_sts_t;

endpackage

// File: hw/rtl/bsc_if.sv
// ----------------------------------------------------------------------------
// Byte substitution cipher channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface bsc_req_if import bsc_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  byte_t data_in;
  byte_t key_index;

  modport source (output valid, output command, output data_in, output key_index,
                  input ready);
  modport sink   (input valid, input command, input data_in, input key_index,
                  output ready);
endinterface

interface bsc_rsp_if import bsc_pkg::*; ();
  logic    valid;
  logic    ready;
  byte_t   data_out;
  status_t status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface

// File: hw/rtl/bsc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned Aw   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// Byte substitution cipher datapath
// Tables, seed and staging stores, loop counters and the response register.
// ----------------------------------------------------------------------------
module bsc_datapath import bsc_pkg::*; #(
  parameter int unsigned SEED_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bsc_cmd_t cmd_i,
  output bsc_sts_t sts_o,
  // request side
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  cmd_t     req_command_i,
  input  byte_t    req_data_i,
  input  byte_t    req_index_i,
  // response side
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output byte_t    rsp_data_o,
  output status_t  rsp_status_o
);

  localparam int unsigned SeedAw   = (SEED_DEPTH > 1) ? $clog2(SEED_DEPTH) : 1;
  localparam int unsigned SeedCntW = $clog2(SEED_DEPTH + 1);

  // Request registers
  cmd_t  cmd_q;
  byte_t data_q, idx_q;
  logic  accepted;

  assign req_ready_o = cmd_i.take;
  assign accepted    = req_valid_i & cmd_i.take;

  always_ff @(posedge clk_i) begin
    if (accepted) begin
      cmd_q  <= req_command_i;
      data_q <= req_data_i;
      idx_q  <= req_index_i;
    end
  end

  // Counters and flags
  byte_t                k_q;
  logic [SeedAw-1:0]    sp_q;
  logic [SeedCntW-1:0]  seed_cnt_q;
  logic [MarkCntW-1:0]  mark_cnt_q;
  logic [TableSize-1:0] marks_q;
  logic [TableSize-1:0] inv_valid_q;
  logic                 fwd_loaded_q;
  logic                 inv_hit_q;
  byte_t                j_q, a_q;
  status_e              st_q;

  byte_t fwd_rdata, inv_rdata, stg_rdata, seed_rdata;
  logic  sp_wrap;

  assign sp_wrap = (SeedCntW'(sp_q) + SeedCntW'(1)) == seed_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q          <= '0;
      sp_q         <= '0;
      seed_cnt_q   <= '0;
      mark_cnt_q   <= '0;
      marks_q      <= '0;
      inv_valid_q  <= '0;
      fwd_loaded_q <= 1'b0;
      st_q         <= ST_OK;
    end else begin
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + byte_t'(1);
      end
      if (cmd_i.sp_clr) begin
        sp_q <= '0;
      end else if (cmd_i.sp_inc) begin
        sp_q <= sp_wrap ? '0 : sp_q + SeedAw'(1);
      end
      if (cmd_i.seed_clr) begin
        seed_cnt_q <= '0;
      end else if (cmd_i.seed_wr) begin
        seed_cnt_q <= seed_cnt_q + SeedCntW'(1);
      end
      if (cmd_i.marks_clr) begin
        marks_q    <= '0;
        mark_cnt_q <= '0;
      end else if (cmd_i.stage_wr) begin
        marks_q[idx_q] <= 1'b1;
        if (!marks_q[idx_q]) begin
          mark_cnt_q <= mark_cnt_q + MarkCntW'(1);
        end
      end
      if (cmd_i.rb_wr) begin
        inv_valid_q[fwd_rdata] <= 1'b1;
      end
      if (cmd_i.gen_init || cmd_i.cp_wr) begin
        fwd_loaded_q <= 1'b1;
      end
      if (cmd_i.st_ld) begin
        st_q <= cmd_i.st;
      end
    end
  end

  // Swap operands and decrypt hit
  always_ff @(posedge clk_i) begin
    if (cmd_i.sw_rd_i) begin
      j_q <= seed_rdata;
    end
    if (cmd_i.sw_rd_j) begin
      a_q <= fwd_rdata;
    end
    if (cmd_i.lookup_rd) begin
      inv_hit_q <= inv_valid_q[data_q];
    end
  end

  // Forward table
  logic  fwd_we, fwd_re;
  byte_t fwd_waddr, fwd_wdata, fwd_raddr;

  always_comb begin
    fwd_re    = cmd_i.sw_rd_i | cmd_i.sw_rd_j | cmd_i.rb_rd |
                (cmd_i.lookup_rd & (cmd_q == CMD_ENCRYPT));
    fwd_raddr = data_q;
    if (cmd_i.sw_rd_i || cmd_i.rb_rd) begin
      fwd_raddr = k_q;
    end else if (cmd_i.sw_rd_j) begin
      fwd_raddr = j_q;
    end
    fwd_we    = cmd_i.gen_init | cmd_i.sw_wr_i | cmd_i.sw_wr_j | cmd_i.cp_wr;
    fwd_waddr = cmd_i.sw_wr_j ? j_q : k_q;
    fwd_wdata = k_q;
    if (cmd_i.sw_wr_i) begin
      fwd_wdata = fwd_rdata;
    end else if (cmd_i.sw_wr_j) begin
      fwd_wdata = a_q;
    end else if (cmd_i.cp_wr) begin
      fwd_wdata = stg_rdata;
    end
  end

  bsc_ram #(.WIDTH(ByteW), .DEPTH(TableSize)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .re_i    (fwd_re),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  bsc_ram #(.WIDTH(ByteW), .DEPTH(TableSize)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rb_wr),
    .waddr_i (fwd_rdata),
    .wdata_i (k_q),
    .re_i    (cmd_i.lookup_rd & (cmd_q == CMD_DECRYPT)),
    .raddr_i (data_q),
    .rdata_o (inv_rdata)
  );

  bsc_ram #(.WIDTH(ByteW), .DEPTH(TableSize)) u_stg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.stage_wr),
    .waddr_i (idx_q),
    .wdata_i (data_q),
    .re_i    (cmd_i.cp_rd),
    .raddr_i (k_q),
    .rdata_o (stg_rdata)
  );

  bsc_ram #(.WIDTH(ByteW), .DEPTH(SEED_DEPTH)) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seed_wr),
    .waddr_i (seed_cnt_q[SeedAw-1:0]),
    .wdata_i (data_q),
    .re_i    (cmd_i.sw_seed_rd),
    .raddr_i (sp_q),
    .rdata_o (seed_rdata)
  );

  // Response register
  logic    out_valid_q;
  byte_t   out_data_q, out_data_d;
  status_t out_status_q;

  always_comb begin
    case (cmd_q)
      CMD_ENCRYPT: out_data_d = fwd_loaded_q ? fwd_rdata : '0;
      CMD_DECRYPT: out_data_d = inv_hit_q ? inv_rdata : '0;
      default:     out_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q   <= out_data_d;
      out_status_q <= st_q;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_data_o   = out_data_q;
  assign rsp_status_o = out_status_q;

  assign sts_o.accepted     = accepted;
  assign sts_o.command      = cmd_q;
  assign sts_o.seed_empty   = (seed_cnt_q == '0);
  assign sts_o.seed_full    = (seed_cnt_q == SeedCntW'(SEED_DEPTH));
  assign sts_o.key_complete = (mark_cnt_q == MarkCntW'(TableSize));
  assign sts_o.k_last       = (k_q == byte_t'(TableSize - 1));
  assign sts_o.out_free     = ~out_valid_q | rsp_ready_i;

endmodule

// File: hw/rtl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// Byte substitution cipher controller
// Sequences request decode, key generation, commit copy and inverse rebuild.
// ----------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bsc_sts_t sts_i,
  output bsc_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DECODE  = 13'b0000000000010,
    S_INIT    = 13'b0000000000100,
    S_SW_SEED = 13'b0000000001000,
    S_SW_RDI  = 13'b0000000010000,
    S_SW_RDJ  = 13'b0000000100000,
    S_SW_WRI  = 13'b0000001000000,
    S_SW_WRJ  = 13'b0000010000000,
    S_CP_RD   = 13'b0000100000000,
    S_CP_WR   = 13'b0001000000000,
    S_RB_RD   = 13'b0010000000000,
    S_RB_WR   = 13'b0100000000000,
    S_RESP    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.accepted) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.st_ld = 1'b1;
        cmd_o.st    = ST_OK;
        state_d     = S_RESP;
        case (sts_i.command)
          CMD_LOAD_SEED: begin
            if (sts_i.seed_full) begin
              cmd_o.st = ST_SEED_FULL;
            end else begin
              cmd_o.seed_wr = 1'b1;
            end
          end
          CMD_GEN_KEY: begin
            if (sts_i.seed_empty) begin
              cmd_o.st = ST_SEED_EMPTY;
            end else begin
              cmd_o.k_clr = 1'b1;
              state_d     = S_INIT;
            end
          end
          CMD_STAGE: cmd_o.stage_wr = 1'b1;
          CMD_COMMIT: begin
            if (!sts_i.key_complete) begin
              cmd_o.st = ST_INCOMPLETE;
            end else begin
              cmd_o.marks_clr = 1'b1;
              cmd_o.k_clr     = 1'b1;
              state_d         = S_CP_RD;
            end
          end
          CMD_ENCRYPT, CMD_DECRYPT: cmd_o.lookup_rd = 1'b1;
          default: ;
        endcase
      end
      // Fill the forward table with the identity
      S_INIT: begin
        cmd_o.gen_init = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.k_clr  = 1'b1;
          cmd_o.sp_clr = 1'b1;
          state_d      = S_SW_SEED;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      S_SW_SEED: begin
        cmd_o.sw_seed_rd = 1'b1;
        state_d          = S_SW_RDI;
      end
      S_SW_RDI: begin
        cmd_o.sw_rd_i = 1'b1;
        state_d       = S_SW_RDJ;
      end
      S_SW_RDJ: begin
        cmd_o.sw_rd_j = 1'b1;
        state_d       = S_SW_WRI;
      end
      S_SW_WRI: begin
        cmd_o.sw_wr_i = 1'b1;
        state_d       = S_SW_WRJ;
      end
      S_SW_WRJ: begin
        cmd_o.sw_wr_j = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.k_clr    = 1'b1;
          cmd_o.seed_clr = 1'b1;
          state_d        = S_RB_RD;
        end else begin
          cmd_o.k_inc  = 1'b1;
          cmd_o.sp_inc = 1'b1;
          state_d      = S_SW_SEED;
        end
      end
      S_CP_RD: begin
        cmd_o.cp_rd = 1'b1;
        state_d     = S_CP_WR;
      end
      S_CP_WR: begin
        cmd_o.cp_wr = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_RB_RD;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_CP_RD;
        end
      end
      S_RB_RD: begin
        cmd_o.rb_rd = 1'b1;
        state_d     = S_RB_WR;
      end
      S_RB_WR: begin
        cmd_o.rb_wr = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_RESP;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_RB_RD;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/byte_substitution_cipher_unit.sv
// Load seed, stage, encrypt, decrypt, unused codes and every rejected request go from
//   decode straight to the response state; one request is handled at a time.
// Generate key: identity fill, per-entry swap (seed read, read i, read j, write i, write j),
//   then inverse rebuild. Commit key: per-entry copy (read, write), then the rebuild.
// Each state makes at most one table access, with registered reads. Reset clears
//   control state at once; tables read as zero until loaded (forward: one flag; inverse: valid bits).
// ----------------------------------------------------------------------------
// Byte substitution cipher unit
// Seeded key generation, staged key commit, and byte encrypt/decrypt via
// a 256-entry substitution table and its inverse.
// ----------------------------------------------------------------------------
module byte_substitution_cipher_unit import bsc_pkg::*; #(
  parameter int unsigned SEED_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsc_req_if.sink    req_i,
  bsc_rsp_if.source  rsp_o
);

  // Commands from the controller, status back from the datapath
  bsc_cmd_t cmd;
  bsc_sts_t sts;

  // Controller: one request at a time, hold in the response state until the
  // output register can take the result.
  bsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: tables, seed and staging stores, counters, response register.
  bsc_datapath #(.SEED_DEPTH(SEED_DEPTH)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_command_i (req_i.command),
    .req_data_i    (req_i.data_in),
    .req_index_i   (req_i.key_index),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_data_o    (rsp_o.data_out),
    .rsp_status_o  (rsp_o.status)
  );

endmodule
